// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define PXR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked at the next rising edge outside reset
`define PXR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pxr_pkg.sv =====
// ----------------------------------------------------------------------------
// pxr_pkg
// shared types and constants of the pixel address remapper
// ----------------------------------------------------------------------------
package pxr_pkg;

  // field widths
  localparam int SensorW = 6;
  localparam int CoordW  = 12;
  localparam int GeoW    = 14;
  localparam int CfgW    = 64;
  localparam int CfgIdxW = 3;

  // number of table entries the hardware holds
  localparam logic [1:0] DutEntries = 2'd2;

  // default sensor size when no table entry matches
  localparam logic [CoordW-1:0] DefaultColumns = 12'd80;
  localparam logic [CoordW-1:0] DefaultRows    = 12'd336;

  // sensor sizes with a special remapping
  localparam logic [CoordW-1:0] IlvColumns = 12'd40;
  localparam logic [CoordW-1:0] IlvRows    = 12'd672;
  localparam logic [CoordW-1:0] HexColumns = 12'd120;
  localparam logic [CoordW-1:0] HexRows    = 12'd134;

  // reciprocal of five for 12-bit values: x / 5 == (x * 3277) >> 14
  localparam logic [CoordW-1:0] RecipFive = 12'd3277;
  localparam int RecipShift = 14;

  // -1 in the geometric coordinate encoding
  localparam logic [GeoW-1:0] GeoUndef = {GeoW{1'b1}};

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDutCount   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDut0Sensor = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDut0Cols   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDut0Rows   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDut1Sensor = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDut1Cols   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDut1Rows   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegExclMask   = 3'd7;

  // configuration register contents
  typedef struct packed {
    logic [1:0]         dut_count;
    logic [SensorW-1:0] dut0_sensor;
    logic [CoordW-1:0]  dut0_columns;
    logic [CoordW-1:0]  dut0_rows;
    logic [SensorW-1:0] dut1_sensor;
    logic [CoordW-1:0]  dut1_columns;
    logic [CoordW-1:0]  dut1_rows;
    logic [CfgW-1:0]    excluded_mask;
  } cfg_t;

  // mapping result of one hit
  typedef struct packed {
    logic            keep;
    logic [GeoW-1:0] geo_column;
    logic [GeoW-1:0] geo_row;
  } geo_res_t;

endpackage

// ===== sv/pxr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pxr_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module pxr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pxr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pxr_pkg::CfgW-1:0]     cfg_wdata_i,
  output pxr_pkg::cfg_t                cfg_o
);

  pxr_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pxr_pkg::RegDutCount:   cfg_d.dut_count     = cfg_wdata_i[1:0];
        pxr_pkg::RegDut0Sensor: cfg_d.dut0_sensor   = cfg_wdata_i[pxr_pkg::SensorW-1:0];
        pxr_pkg::RegDut0Cols:   cfg_d.dut0_columns  = cfg_wdata_i[pxr_pkg::CoordW-1:0];
        pxr_pkg::RegDut0Rows:   cfg_d.dut0_rows     = cfg_wdata_i[pxr_pkg::CoordW-1:0];
        pxr_pkg::RegDut1Sensor: cfg_d.dut1_sensor   = cfg_wdata_i[pxr_pkg::SensorW-1:0];
        pxr_pkg::RegDut1Cols:   cfg_d.dut1_columns  = cfg_wdata_i[pxr_pkg::CoordW-1:0];
        pxr_pkg::RegDut1Rows:   cfg_d.dut1_rows     = cfg_wdata_i[pxr_pkg::CoordW-1:0];
        pxr_pkg::RegExclMask:   cfg_d.excluded_mask = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dut_count     <= '0;
      cfg_q.dut0_sensor   <= '0;
      cfg_q.dut0_columns  <= pxr_pkg::DefaultColumns;
      cfg_q.dut0_rows     <= pxr_pkg::DefaultRows;
      cfg_q.dut1_sensor   <= '0;
      cfg_q.dut1_columns  <= pxr_pkg::DefaultColumns;
      cfg_q.dut1_rows     <= pxr_pkg::DefaultRows;
      cfg_q.excluded_mask <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/pxr_geo_map.sv =====
// ----------------------------------------------------------------------------
// pxr_geo_map
// sensor size lookup and raw-to-geometric coordinate remapping of one hit
// ----------------------------------------------------------------------------
module pxr_geo_map (
  input  pxr_pkg::cfg_t                cfg_i,
  input  logic [pxr_pkg::SensorW-1:0]  sensor_i,
  input  logic [pxr_pkg::CoordW-1:0]   column_i,
  input  logic [pxr_pkg::CoordW-1:0]   row_i,
  output pxr_pkg::geo_res_t            res_o
);

  localparam int CW = pxr_pkg::CoordW;
  localparam int GW = pxr_pkg::GeoW;

  logic [1:0]      used;
  logic [CW-1:0]   n_cols;
  logic [CW-1:0]   n_rows;
  logic            excluded;
  logic [2*CW-1:0] recip_prod;
  logic [9:0]      quot5;
  logic [CW-1:0]   rem_full;
  logic [2:0]      r5;
  logic [1:0]      c4;
  logic            outer;
  logic [GW-1:0]   col3;
  logic [GW-1:0]   col3_inc;
  logic [GW-1:0]   base_col;
  logic [GW-1:0]   low_col;
  logic [GW-1:0]   high_col;
  logic [GW-1:0]   two_q;

  // entries in use, clamped to the table size
  always_comb begin
    used = (cfg_i.dut_count > 2'd2) ? 2'd2 : cfg_i.dut_count;
    if (used > pxr_pkg::DutEntries) begin
      used = pxr_pkg::DutEntries;
    end
  end

  // sensor size lookup, second entry wins
  always_comb begin
    n_cols = pxr_pkg::DefaultColumns;
    n_rows = pxr_pkg::DefaultRows;
    if (used >= 2'd1 && cfg_i.dut0_sensor == sensor_i) begin
      n_cols = cfg_i.dut0_columns;
      n_rows = cfg_i.dut0_rows;
    end
    if (used >= 2'd2 && cfg_i.dut1_sensor == sensor_i) begin
      n_cols = cfg_i.dut1_columns;
      n_rows = cfg_i.dut1_rows;
    end
  end

  assign excluded = cfg_i.excluded_mask[sensor_i];

  // row split into row / 5 and row % 5 by reciprocal multiply
  assign recip_prod = row_i * pxr_pkg::RecipFive;
  assign quot5      = recip_prod[pxr_pkg::RecipShift +: 10];
  assign rem_full   = row_i - {quot5, 2'b00} - {2'b00, quot5};
  assign r5         = rem_full[2:0];
  assign two_q      = {{(GW-11){1'b0}}, quot5, 1'b0};

  // column phase and the three column candidates around 3c/2
  assign c4       = column_i[1:0];
  assign outer    = (c4 == 2'd0) || (c4 == 2'd3);
  assign col3     = {1'b0, column_i, 1'b0} + {2'b00, column_i};
  assign col3_inc = col3 + 14'd1;
  assign base_col = {1'b0, col3_inc[GW-1:1]};
  // floor of 3c/2, only taken for odd columns
  assign low_col  = {1'b0, col3[GW-1:1]};
  assign high_col = {1'b0, col3[GW-1:1]} + 14'd1;

  // remapping by sensor size
  always_comb begin
    res_o.keep       = !excluded;
    res_o.geo_column = {2'b00, column_i};
    res_o.geo_row    = {2'b00, row_i};
    if (n_cols == pxr_pkg::IlvColumns && n_rows == pxr_pkg::IlvRows) begin
      // odd and even columns folded into doubled rows
      res_o.geo_column = {3'b000, column_i[CW-1:1]};
      res_o.geo_row    = {1'b0, row_i, ~column_i[0]};
    end else if (n_cols == pxr_pkg::HexColumns && n_rows == pxr_pkg::HexRows) begin
      res_o.geo_column = base_col;
      res_o.geo_row    = pxr_pkg::GeoUndef;
      case (r5)
        3'd2: res_o.geo_row = two_q;
        3'd4: res_o.geo_row = two_q + 14'd1;
        3'd1: begin
          if (outer) begin
            res_o.keep = 1'b0;
          end else begin
            res_o.geo_row    = two_q + 14'd1;
            res_o.geo_column = (c4 == 2'd1) ? low_col : high_col;
          end
        end
        3'd3: begin
          if (outer) begin
            res_o.keep = 1'b0;
          end
        end
        3'd0: begin
          if (outer) begin
            res_o.geo_row    = two_q;
            res_o.geo_column = (c4 == 2'd3) ? low_col : high_col;
          end
        end
        default: res_o.geo_row = pxr_pkg::GeoUndef;
      endcase
    end
  end

endmodule

// ===== sv/pixel_address_remapper_core.sv =====
// ----------------------------------------------------------------------------
// pixel_address_remapper_core
// remaps one hit pixel a cycle from raw to geometric sensor coordinates
// ----------------------------------------------------------------------------
// The block takes one hit per clock: busy is always low, so a hit offered on
// start is taken at every edge. Each hit goes through the input register and
// the result register to the result ports, where its result is marked
// by out_strobe_o for exactly one cycle; the receiver has to capture it
// then, it cannot stall the block. Hits of an excluded sensor, and hits that
// the 120 by 134 pattern drops, give no beat.
// The input register and the result register sit around the size lookup
// and remapping logic. Configuration is to be written only
// while no hit is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_address_remapper_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [pxr_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pxr_pkg::CfgW-1:0]            cfg_wdata_i,
  // hit input
  input  logic                                start,
  output logic                                busy,
  input  logic [pxr_pkg::SensorW-1:0]         sensor_id_i,
  input  logic [pxr_pkg::CoordW-1:0]          hit_column_i,
  input  logic [pxr_pkg::CoordW-1:0]          hit_row_i,
  // result output
  output logic                                out_strobe_o,
  output logic [pxr_pkg::SensorW-1:0]         out_sensor_o,
  output logic [pxr_pkg::CoordW-1:0]          raw_column_o,
  output logic [pxr_pkg::CoordW-1:0]          raw_row_o,
  output logic signed [pxr_pkg::GeoW-1:0]     geo_column_o,
  output logic signed [pxr_pkg::GeoW-1:0]     geo_row_o
);

  pxr_pkg::cfg_t                cfg;
  pxr_pkg::geo_res_t            map_res;

  logic                         in_valid_q;
  logic [pxr_pkg::SensorW-1:0]  in_sensor_q;
  logic [pxr_pkg::CoordW-1:0]   in_column_q;
  logic [pxr_pkg::CoordW-1:0]   in_row_q;

  logic                         out_valid_q;
  logic [pxr_pkg::SensorW-1:0]  out_sensor_q;
  logic [pxr_pkg::CoordW-1:0]   out_column_q;
  logic [pxr_pkg::CoordW-1:0]   out_row_q;
  logic [pxr_pkg::GeoW-1:0]     geo_column_q;
  logic [pxr_pkg::GeoW-1:0]     geo_row_q;

  // never stalls
  assign busy = 1'b0;

  // configuration registers
  pxr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_sensor_q <= sensor_id_i;
      in_column_q <= hit_column_i;
      in_row_q    <= hit_row_i;
    end
  end

  // lookup and remapping
  pxr_geo_map u_geo_map (
    .cfg_i    (cfg),
    .sensor_i (in_sensor_q),
    .column_i (in_column_q),
    .row_i    (in_row_q),
    .res_o    (map_res)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q && map_res.keep;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      out_sensor_q <= in_sensor_q;
      out_column_q <= in_column_q;
      out_row_q    <= in_row_q;
      geo_column_q <= map_res.geo_column;
      geo_row_q    <= map_res.geo_row;
    end
  end

  assign out_strobe_o = out_valid_q;
  assign out_sensor_o = out_sensor_q;
  assign raw_column_o = out_column_q;
  assign raw_row_o    = out_row_q;
  assign geo_column_o = $signed(geo_column_q);
  assign geo_row_o    = $signed(geo_row_q);

  // checks
  `PXR_ASSERT_IMPL(a_beat_from_hit, out_strobe_o, $past(in_valid_q), "result beat without a hit")
  `PXR_ASSERT_NEXT(a_sensor_carried, in_valid_q && map_res.keep, out_sensor_o == $past(in_sensor_q), "sensor id not carried")
  `PXR_ASSERT_IMPL(a_column_defined, out_strobe_o, geo_column_q != pxr_pkg::GeoUndef, "geometric column undefined")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the pixel address remapper. Hits are driven on the start/busy
// port and every result beat is checked against an in-bench predictor of the
// size lookup and the interleaved and hexagonal remappings. It covers
// directed corner hits, then random hits under several table settings, with
// sender gaps of changing density.
// ----------------------------------------------------------------------------
module tb_top;
  import pxr_pkg::*;

  // one result beat: raw hit plus its geometric coordinates
  typedef struct packed {
    logic [SensorW-1:0] sensor;
    logic [CoordW-1:0]  column;
    logic [CoordW-1:0]  row;
    logic [GeoW-1:0]    geo_column;
    logic [GeoW-1:0]    geo_row;
  } pixel_beat_t;

  // predicted beats and the register copy they are predicted from
  class remap_scoreboard;
    cfg_t          regs;
    pixel_beat_t   pending_q[$];
    int unsigned   errors;

    function void reset_regs();
      regs = '0;
      regs.dut0_columns = DefaultColumns;
      regs.dut0_rows    = DefaultRows;
      regs.dut1_columns = DefaultColumns;
      regs.dut1_rows    = DefaultRows;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        RegDutCount:   regs.dut_count     = data[1:0];
        RegDut0Sensor: regs.dut0_sensor   = data[SensorW-1:0];
        RegDut0Cols:   regs.dut0_columns  = data[CoordW-1:0];
        RegDut0Rows:   regs.dut0_rows     = data[CoordW-1:0];
        RegDut1Sensor: regs.dut1_sensor   = data[SensorW-1:0];
        RegDut1Cols:   regs.dut1_columns  = data[CoordW-1:0];
        RegDut1Rows:   regs.dut1_rows     = data[CoordW-1:0];
        RegExclMask:   regs.excluded_mask = data;
        default: ;
      endcase
    endfunction

    // size lookup and remapping of one hit
    function geo_res_t remap(logic [SensorW-1:0] sensor, logic [CoordW-1:0] col_in,
                             logic [CoordW-1:0] row_in);
      geo_res_t          res;
      logic [1:0]        used;
      logic [CoordW-1:0] ncol, nrow;
      int                col, row, gc, gr, c4, r5;
      bit                outer;
      col = col_in;
      row = row_in;
      res.keep = 1'b0;
      res.geo_column = GeoUndef;
      res.geo_row = GeoUndef;
      if (regs.excluded_mask[sensor]) return res;
      used = (regs.dut_count > DutEntries) ? DutEntries : regs.dut_count;
      ncol = DefaultColumns;
      nrow = DefaultRows;
      if (used >= 1 && regs.dut0_sensor == sensor) begin
        ncol = regs.dut0_columns;
        nrow = regs.dut0_rows;
      end
      // second entry wins when both match
      if (used >= 2 && regs.dut1_sensor == sensor) begin
        ncol = regs.dut1_columns;
        nrow = regs.dut1_rows;
      end
      gc = -1;
      gr = -1;
      if (ncol == IlvColumns && nrow == IlvRows) begin
        // odd and even columns folded into doubled rows
        if (col % 2 == 1) begin
          gr = row * 2;
          gc = (col - 1) / 2;
        end else begin
          gr = row * 2 + 1;
          gc = col / 2;
        end
      end else if (ncol == HexColumns && nrow == HexRows) begin
        c4 = col % 4;
        r5 = row % 5;
        outer = (c4 == 0 || c4 == 3);
        // outer columns on odd row phases have no pixel
        if (outer && (r5 == 1 || r5 == 3)) return res;
        gc = (col % 2 == 0) ? (col * 3) / 2 : (col * 3 + 1) / 2;
        if (r5 == 2) begin
          gr = ((row - 2) * 2) / 5;
        end else if (r5 == 4) begin
          gr = (row * 2 - 3) / 5;
        end else if (!outer && r5 == 1) begin
          gr = (row * 2 + 3) / 5;
          gc = (c4 == 1) ? (col * 3 - 1) / 2 : (col * 3) / 2 + 1;
        end else if (outer && r5 == 0) begin
          gr = (row * 2) / 5;
          gc = (c4 == 3) ? (col * 3 - 1) / 2 : (col * 3) / 2 + 1;
        end
        // inner columns on row phases 0 and 3 keep geo_row undefined
      end else begin
        gc = col;
        gr = row;
      end
      res.keep = 1'b1;
      res.geo_column = gc[GeoW-1:0];
      res.geo_row = gr[GeoW-1:0];
      return res;
    endfunction

    function void note_hit(logic [SensorW-1:0] sensor, logic [CoordW-1:0] col,
                           logic [CoordW-1:0] row);
      geo_res_t    res;
      pixel_beat_t beat;
      res = remap(sensor, col, row);
      beat = {sensor, col, row, res.geo_column, res.geo_row};
      if (res.keep) pending_q.insert(pending_q.size(), beat);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_beat(pixel_beat_t got);
      pixel_beat_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("beat with none predicted: sensor %0d col %0d row %0d",
                         got.sensor, got.column, got.row));
        return;
      end
      want = pending_q.pop_front();
      cmp_field("out_sensor", got.sensor, want.sensor);
      cmp_field("raw_column", got.column, want.column);
      cmp_field("raw_row", got.row, want.row);
      cmp_field("geo_column", got.geo_column, want.geo_column);
      cmp_field("geo_row", got.geo_row, want.geo_row);
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic [SensorW-1:0]   sensor_id_i;
  logic [CoordW-1:0]    hit_column_i;
  logic [CoordW-1:0]    hit_row_i;
  logic                 out_strobe_o;
  logic [SensorW-1:0]   out_sensor_o;
  logic [CoordW-1:0]    raw_column_o;
  logic [CoordW-1:0]    raw_row_o;
  logic signed [GeoW-1:0] geo_column_o;
  logic signed [GeoW-1:0] geo_row_o;
  pixel_beat_t          out_beat;
  remap_scoreboard      sb;

  pixel_address_remapper_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .sensor_id_i  (sensor_id_i),
    .hit_column_i (hit_column_i),
    .hit_row_i    (hit_row_i),
    .out_strobe_o (out_strobe_o),
    .out_sensor_o (out_sensor_o),
    .raw_column_o (raw_column_o),
    .raw_row_o    (raw_row_o),
    .geo_column_o (geo_column_o),
    .geo_row_o    (geo_row_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  assign out_beat = {out_sensor_o, raw_column_o, raw_row_o, geo_column_o, geo_row_o};

  // check result beats, record accepted hits
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_strobe_o) sb.check_beat(out_beat);
      if (start && !busy) sb.note_hit(sensor_id_i, hit_column_i, hit_row_i);
    end
  end

  // hold start low with random contents on the fields
  task automatic pause(int n);
    start        <= 1'b0;
    sensor_id_i  <= SensorW'($urandom);
    hit_column_i <= CoordW'($urandom);
    hit_row_i    <= CoordW'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // offer one hit after a random gap, return at the edge that takes it
  task automatic send_hit(logic [SensorW-1:0] sensor, logic [CoordW-1:0] col,
                          logic [CoordW-1:0] row, int gap_pct);
    int n;
    n = 0;
    while ($urandom_range(99) < gap_pct) n++;
    if (n > 0) pause(n);
    start        <= 1'b1;
    sensor_id_i  <= sensor;
    hit_column_i <= col;
    hit_row_i    <= row;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // stop sending and let every predicted beat arrive, plus pipeline slack
  task automatic wait_idle();
    int cnt;
    cnt = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0 && cnt < 200) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.pending_q.size() != 0) begin
      sb.report($sformatf("%0d predicted beats never came", sb.pending_q.size()));
      sb.pending_q.delete();
    end
  endtask

  // register data with random bits above the register width
  function automatic logic [CfgW-1:0] pad(logic [CfgW-1:0] v, int w);
    logic [CfgW-1:0] junk;
    junk = {$urandom, $urandom};
    return (w >= CfgW) ? v : ((junk << w) | (v & ((64'd1 << w) - 1)));
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // rewrite the whole register set, block must be idle
  task automatic apply_config(logic [1:0] cnt, logic [SensorW-1:0] s0,
                              logic [CoordW-1:0] c0, logic [CoordW-1:0] r0,
                              logic [SensorW-1:0] s1, logic [CoordW-1:0] c1,
                              logic [CoordW-1:0] r1, logic [CfgW-1:0] mask);
    write_reg(RegDutCount, pad(cnt, 2));
    write_reg(RegDut0Sensor, pad(s0, SensorW));
    write_reg(RegDut0Cols, pad(c0, CoordW));
    write_reg(RegDut0Rows, pad(r0, CoordW));
    write_reg(RegDut1Sensor, pad(s1, SensorW));
    write_reg(RegDut1Cols, pad(c1, CoordW));
    write_reg(RegDut1Rows, pad(r1, CoordW));
    write_reg(RegExclMask, mask);
    cfg_we_i <= 1'b0;
  endtask

  // sensor size, mostly the special ones and their near misses
  task automatic pick_size(output logic [CoordW-1:0] c, output logic [CoordW-1:0] r);
    case ($urandom_range(7))
      0, 1:    begin c = IlvColumns; r = IlvRows; end
      2, 3:    begin c = HexColumns; r = HexRows; end
      4:       begin c = DefaultColumns; r = DefaultRows; end
      5:       begin c = IlvColumns; r = HexRows; end
      6:       begin c = HexColumns; r = IlvRows; end
      default: begin c = CoordW'($urandom); r = CoordW'($urandom); end
    endcase
  endtask

  // stimulus
  initial begin
    int                gap_pct;
    int                hold_at;
    logic [SensorW-1:0] s0, s1, sensor;
    logic [CoordW-1:0] c0, r0, c1, r1;
    logic [CfgW-1:0]   mask;
    sb = new();
    sb.reset_regs();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    start        = 1'b0;
    sensor_id_i  = '0;
    hit_column_i = '0;
    hit_row_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no table entry, default size passes through
    send_hit(0, 0, 0, 0);
    send_hit(63, 4095, 4095, 0);
    wait_idle();

    // one entry in use: interleaved sensor, second entry ignored
    apply_config(1, 5, IlvColumns, IlvRows, 5, HexColumns, HexRows, '0);
    send_hit(5, 7, 3, 0);
    send_hit(5, 8, 3, 0);
    send_hit(5, 4095, 4095, 0);
    send_hit(5, 0, 0, 0);
    wait_idle();

    // count beyond two, both entries match: hexagonal size wins
    apply_config(3, 9, IlvColumns, IlvRows, 9, HexColumns, HexRows,
                 64'h8000_0000_0000_0001);
    for (int c4 = 0; c4 < 4; c4++)
      for (int r5 = 0; r5 < 5; r5++)
        send_hit(9, 12 + c4, 20 + r5, 0);
    send_hit(63, 100, 100, 0);
    send_hit(0, 100, 100, 0);
    send_hit(1, 4095, 0, 0);
    wait_idle();

    // register extremes, every sensor excluded
    apply_config(2, 0, 0, 0, 63, 4095, 4095, '1);
    send_hit(0, 4095, 4095, 0);
    send_hit(63, 0, 0, 0);
    wait_idle();

    // random part: sender gaps sparse, dense, then none
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 28 : (ph == 1) ? 67 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        s0 = SensorW'($urandom);
        s1 = $urandom_range(1) ? s0 : 6'($urandom);
        pick_size(c0, r0);
        pick_size(c1, r1);
        case ($urandom_range(4))
          0, 1:    mask = '0;
          2, 3:    mask = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
          default: mask = {$urandom, $urandom};
        endcase
        apply_config(2'($urandom_range(3)), s0, c0, r0, s1, c1, r1, mask);
        hold_at = $urandom_range(20, 120);
        for (int i = 0; i < 142; i++) begin
          if (i == hold_at) wait_idle();
          case ($urandom_range(9))
            0, 1, 2, 3: sensor = s0;
            4, 5, 6:    sensor = s1;
            default:    sensor = SensorW'($urandom);
          endcase
          send_hit(sensor, CoordW'($urandom), CoordW'($urandom), gap_pct);
        end
        wait_idle();
      end
    end

    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
